FILE: src/rnc_pkg.sv
// rnc_pkg: shared types, codes and defaults of the rectangle neighbor classifier.
// No dependencies; every other file imports it.
package rnc_pkg;

    localparam int MAX_PARTS_DEF  = 32;
    localparam int COORD_BITS_DEF = 16;

    localparam int ID_W       = 5;
    localparam int FIELD_W    = 16;
    localparam int CNT_OUT_W  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int GRP_NUM    = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_X_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_X_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_Y_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_Y_HIGH = 3'd4;

    typedef enum logic [2:0] {
        POS_UP        = 3'd0,
        POS_DOWN      = 3'd1,
        POS_RIGHT     = 3'd2,
        POS_LEFT      = 3'd3,
        POS_UPLEFT    = 3'd4,
        POS_UPRIGHT   = 3'd5,
        POS_DOWNLEFT  = 3'd6,
        POS_DOWNRIGHT = 3'd7
    } t_pos;

    // emission groups, in emission order
    typedef enum logic [1:0] {
        GRP_SMALL_SIDE   = 2'd0,
        GRP_LARGE_SIDE   = 2'd1,
        GRP_SMALL_CORNER = 2'd2,
        GRP_LARGE_CORNER = 2'd3
    } t_grp;

    typedef enum logic [1:0] {
        KIND_BOTH  = 2'd0,
        KIND_UP    = 2'd1,
        KIND_RIGHT = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    // classifier result for one offered rectangle
    typedef struct packed {
        logic               hit;
        t_pos               pos;
        logic [FIELD_W-1:0] sx;
        logic [FIELD_W-1:0] sy;
        logic [FIELD_W-1:0] len;
    } t_class;

    // one stored neighbor
    typedef struct packed {
        logic [ID_W-1:0]    id;
        t_pos               pos;
        logic [FIELD_W-1:0] sx;
        logic [FIELD_W-1:0] sy;
        logic [FIELD_W-1:0] len;
    } t_entry;

    function automatic t_grp grp_of(input t_pos pos);
        t_grp g;
        case (pos)
            POS_UP, POS_RIGHT:            g = GRP_LARGE_SIDE;
            POS_DOWN, POS_LEFT:           g = GRP_SMALL_SIDE;
            POS_UPLEFT, POS_UPRIGHT:      g = GRP_LARGE_CORNER;
            POS_DOWNLEFT, POS_DOWNRIGHT:  g = GRP_SMALL_CORNER;
            default:                      g = GRP_SMALL_SIDE;
        endcase
        return g;
    endfunction

endpackage

FILE: src/rnc_in_if.sv
// rnc_in_if: input channel, one partition rectangle per item.
// Depends on rnc_pkg.
interface rnc_in_if import rnc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    rect_id;
    logic [FIELD_W-1:0] rect_x_low;
    logic [FIELD_W-1:0] rect_x_high;
    logic [FIELD_W-1:0] rect_y_low;
    logic [FIELD_W-1:0] rect_y_high;
    logic               rect_last;

    modport source (
        output valid, rect_id, rect_x_low, rect_x_high, rect_y_low, rect_y_high, rect_last,
        input  ready
    );
    modport sink (
        input  valid, rect_id, rect_x_low, rect_x_high, rect_y_low, rect_y_high, rect_last,
        output ready
    );
endinterface

FILE: src/rnc_out_if.sv
// rnc_out_if: result channel, one neighbor entry per item.
// Depends on rnc_pkg.
interface rnc_out_if import rnc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ID_W-1:0]      neighbor_id;
    logic [2:0]           position;
    logic [FIELD_W-1:0]   start_x;
    logic [FIELD_W-1:0]   start_y;
    logic [FIELD_W-1:0]   edge_length;
    logic [1:0]           part_kind;
    logic [CNT_OUT_W-1:0] count_small_sides;
    logic [CNT_OUT_W-1:0] count_large_sides;
    logic [CNT_OUT_W-1:0] count_small_corners;
    logic [CNT_OUT_W-1:0] count_large_corners;
    logic                 entry_valid;
    logic                 run_last;

    modport source (
        output valid, neighbor_id, position, start_x, start_y, edge_length, part_kind,
               count_small_sides, count_large_sides, count_small_corners,
               count_large_corners, entry_valid, run_last,
        input  ready
    );
    modport sink (
        input  valid, neighbor_id, position, start_x, start_y, edge_length, part_kind,
               count_small_sides, count_large_sides, count_small_corners,
               count_large_corners, entry_valid, run_last,
        output ready
    );
endinterface

FILE: src/rect_neighbor_classifier.sv
// rect_neighbor_classifier: top level; load phase, neighbor store and emission walk.
// Depends on rnc_pkg, rnc_in_if, rnc_out_if and rnc_classify.

// Rectangles arrive one per item and are classified in the cycle they are
// accepted, so the load phase takes one item per clock. A kept neighbor is
// written at the fill count into a store of MAX_PARTS-1 entries that has
// one write port and one read port; neighbors beyond that are dropped. The
// item with rect_last closes the run; from then on no input item is taken
// until the run's final result sits in the output register. Emission walks
// the store up to four times, once per group (down/left sides, up/right
// sides, down corners, up corners), each visit of an entry passing through
// ST_READ and then ST_CHECK (read, then check/hand over) because of the
// store's registered read port. The walk stops at the run's final entry.
// A run with no neighbors gives one result with entry_valid low and the
// counts. Every result carries the part kind and the four group counts;
// run_last marks the final one. Reads and writes of the store never overlap
// (load and emission are separate phases), so no forwarding is needed.
// Configuration is written through the plain write port; the user must do
// so only while the block is idle, as the block itself does not enforce it.
module rect_neighbor_classifier import rnc_pkg::*; #(
    parameter int MAX_PARTS  = MAX_PARTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rnc_in_if.sink                i_rect,
    rnc_out_if.source             o_nbr
);

    localparam int STORE_DEPTH = MAX_PARTS - 1;
    localparam int CNT_W       = $clog2(MAX_PARTS);
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_EMPTY = 4'b1000
    } t_state;

    t_state                r_state;
    logic [ID_W-1:0]       r_own_id;
    logic [COORD_BITS-1:0] r_own_xl, r_own_xh, r_own_yl, r_own_yh;
    logic [CNT_W-1:0]      r_store_cnt;
    logic [CNT_W-1:0]      r_grp_cnt [GRP_NUM];
    logic                  r_up_seen, r_right_seen;
    logic [CNT_W-1:0]      r_idx;
    logic [CNT_W-1:0]      r_emit;
    t_grp                  r_grp;
    t_entry                r_store [STORE_DEPTH];
    t_entry                r_rd_data;

    // output register
    logic                  r_out_valid;
    logic [ID_W-1:0]       r_o_id;
    logic [2:0]            r_o_pos;
    logic [FIELD_W-1:0]    r_o_sx, r_o_sy, r_o_len;
    logic [1:0]            r_o_kind;
    logic [CNT_OUT_W-1:0]  r_o_cnt [GRP_NUM];
    logic                  r_o_entry_valid, r_o_run_last;

    // coordinate fields resized to COORD_BITS
    logic [COORD_BITS+FIELD_W-1:0] w_cfg_ext, w_rxl_ext, w_rxh_ext, w_ryl_ext, w_ryh_ext;
    logic [COORD_BITS-1:0]         w_cfg_coord;
    logic [CNT_W+CNT_OUT_W-1:0]    w_cnt_ext [GRP_NUM];

    t_class           w_cls;
    t_entry           w_wr_entry;
    t_grp             w_wr_grp, w_rd_grp;
    t_kind            w_kind;
    logic             w_in_acc, w_store, w_out_free, w_match, w_emit_last, w_idx_end;
    logic             w_load, w_done;
    logic [CNT_W-1:0] w_cnt_after;

    assign w_cfg_ext   = {{COORD_BITS{1'b0}}, i_cfg_data};
    assign w_cfg_coord = w_cfg_ext[COORD_BITS-1:0];
    assign w_rxl_ext   = {{COORD_BITS{1'b0}}, i_rect.rect_x_low};
    assign w_rxh_ext   = {{COORD_BITS{1'b0}}, i_rect.rect_x_high};
    assign w_ryl_ext   = {{COORD_BITS{1'b0}}, i_rect.rect_y_low};
    assign w_ryh_ext   = {{COORD_BITS{1'b0}}, i_rect.rect_y_high};

    rnc_classify #(
        .COORD_BITS (COORD_BITS)
    ) u_classify (
        .i_oxl (r_own_xl),
        .i_oxh (r_own_xh),
        .i_oyl (r_own_yl),
        .i_oyh (r_own_yh),
        .i_rxl (w_rxl_ext[COORD_BITS-1:0]),
        .i_rxh (w_rxh_ext[COORD_BITS-1:0]),
        .i_ryl (w_ryl_ext[COORD_BITS-1:0]),
        .i_ryh (w_ryh_ext[COORD_BITS-1:0]),
        .o_cls (w_cls)
    );

    assign i_rect.ready = (r_state == ST_LOAD);
    assign w_in_acc     = i_rect.valid && i_rect.ready;
    // own id is skipped; a full store drops the neighbor uncounted
    assign w_store      = w_in_acc && (i_rect.rect_id != r_own_id) && w_cls.hit &&
                          (r_store_cnt < CNT_W'(STORE_DEPTH));
    assign w_cnt_after  = w_store ? r_store_cnt + CNT_W'(1) : r_store_cnt;
    assign w_wr_grp     = grp_of(w_cls.pos);

    assign w_wr_entry.id  = i_rect.rect_id;
    assign w_wr_entry.pos = w_cls.pos;
    assign w_wr_entry.sx  = w_cls.sx;
    assign w_wr_entry.sy  = w_cls.sy;
    assign w_wr_entry.len = w_cls.len;

    assign w_out_free  = !r_out_valid || o_nbr.ready;
    assign w_rd_grp    = grp_of(r_rd_data.pos);
    assign w_match     = (w_rd_grp == r_grp);
    assign w_emit_last = ((r_emit + CNT_W'(1)) == r_store_cnt);
    assign w_idx_end   = ((r_idx + CNT_W'(1)) == r_store_cnt);
    assign w_load      = w_out_free &&
                         ((r_state == ST_EMPTY) || (r_state == ST_CHECK && w_match));
    assign w_done      = w_load && ((r_state == ST_EMPTY) || w_emit_last);

    always_comb begin
        if (r_up_seen) begin
            w_kind = r_right_seen ? KIND_BOTH : KIND_UP;
        end else begin
            w_kind = r_right_seen ? KIND_RIGHT : KIND_NONE;
        end
        for (int g = 0; g < GRP_NUM; g++) begin
            w_cnt_ext[g] = {{CNT_OUT_W{1'b0}}, r_grp_cnt[g]};
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_own_id     <= '0;
            r_own_xl     <= '0;
            r_own_xh     <= '0;
            r_own_yl     <= '0;
            r_own_yh     <= '0;
            r_store_cnt  <= '0;
            r_grp_cnt    <= '{default: '0};
            r_up_seen    <= 1'b0;
            r_right_seen <= 1'b0;
            r_idx        <= '0;
            r_emit       <= '0;
            r_grp        <= GRP_SMALL_SIDE;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OWN_ID:     r_own_id <= i_cfg_data[ID_W-1:0];
                    CFG_OWN_X_LOW:  r_own_xl <= w_cfg_coord;
                    CFG_OWN_X_HIGH: r_own_xh <= w_cfg_coord;
                    CFG_OWN_Y_LOW:  r_own_yl <= w_cfg_coord;
                    CFG_OWN_Y_HIGH: r_own_yh <= w_cfg_coord;
                    default: ;
                endcase
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_nbr.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_LOAD: begin
                    if (w_store) begin
                        r_store_cnt         <= w_cnt_after;
                        r_grp_cnt[w_wr_grp] <= r_grp_cnt[w_wr_grp] + CNT_W'(1);
                        if (w_cls.pos == POS_UP) r_up_seen <= 1'b1;
                        if (w_cls.pos == POS_RIGHT) r_right_seen <= 1'b1;
                    end
                    if (w_in_acc && i_rect.rect_last) begin
                        r_idx   <= '0;
                        r_emit  <= '0;
                        r_grp   <= GRP_SMALL_SIDE;
                        r_state <= (w_cnt_after == '0) ? ST_EMPTY : ST_READ;
                    end
                end
                ST_EMPTY: begin
                    if (w_out_free) begin
                        r_store_cnt  <= '0;
                        r_grp_cnt    <= '{default: '0};
                        r_up_seen    <= 1'b0;
                        r_right_seen <= 1'b0;
                        r_state      <= ST_LOAD;
                    end
                end
                ST_READ: begin
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    // a matching entry waits here until the output register frees
                    if (!w_match || w_out_free) begin
                        if (w_match) r_emit <= r_emit + CNT_W'(1);
                        if (w_match && w_emit_last) begin
                            r_store_cnt  <= '0;
                            r_grp_cnt    <= '{default: '0};
                            r_up_seen    <= 1'b0;
                            r_right_seen <= 1'b0;
                            r_state      <= ST_LOAD;
                        end else begin
                            if (w_idx_end) begin
                                r_idx <= '0;
                                r_grp <= t_grp'(r_grp + 2'd1);
                            end else begin
                                r_idx <= r_idx + CNT_W'(1);
                            end
                            r_state <= ST_READ;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    // neighbor store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_store[r_store_cnt[ADDR_W-1:0]] <= w_wr_entry;
        end
        if (r_state == ST_READ) begin
            r_rd_data <= r_store[r_idx[ADDR_W-1:0]];
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_state == ST_EMPTY) begin
                r_o_id          <= '0;
                r_o_pos         <= '0;
                r_o_sx          <= '0;
                r_o_sy          <= '0;
                r_o_len         <= '0;
                r_o_entry_valid <= 1'b0;
            end else begin
                r_o_id          <= r_rd_data.id;
                r_o_pos         <= r_rd_data.pos;
                r_o_sx          <= r_rd_data.sx;
                r_o_sy          <= r_rd_data.sy;
                r_o_len         <= r_rd_data.len;
                r_o_entry_valid <= 1'b1;
            end
            r_o_kind     <= w_kind;
            r_o_run_last <= w_done;
            for (int g = 0; g < GRP_NUM; g++) begin
                r_o_cnt[g] <= w_cnt_ext[g][CNT_OUT_W-1:0];
            end
        end
    end

    assign o_nbr.valid               = r_out_valid;
    assign o_nbr.neighbor_id         = r_o_id;
    assign o_nbr.position            = r_o_pos;
    assign o_nbr.start_x             = r_o_sx;
    assign o_nbr.start_y             = r_o_sy;
    assign o_nbr.edge_length         = r_o_len;
    assign o_nbr.part_kind           = r_o_kind;
    assign o_nbr.count_small_sides   = r_o_cnt[GRP_SMALL_SIDE];
    assign o_nbr.count_large_sides   = r_o_cnt[GRP_LARGE_SIDE];
    assign o_nbr.count_small_corners = r_o_cnt[GRP_SMALL_CORNER];
    assign o_nbr.count_large_corners = r_o_cnt[GRP_LARGE_CORNER];
    assign o_nbr.entry_valid         = r_o_entry_valid;
    assign o_nbr.run_last            = r_o_run_last;

    // checks
    logic [CNT_W+1:0] w_cnt_sum;
    assign w_cnt_sum = (CNT_W+2)'(r_grp_cnt[0]) + (CNT_W+2)'(r_grp_cnt[1]) +
                       (CNT_W+2)'(r_grp_cnt[2]) + (CNT_W+2)'(r_grp_cnt[3]);

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_store_cnt <= CNT_W'(STORE_DEPTH))
        else $error("store fill count beyond depth");

    a_group_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt_sum == (CNT_W+2)'(r_store_cnt))
        else $error("group counts disagree with fill count");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> (r_emit < r_store_cnt && r_idx < r_store_cnt))
        else $error("emission walk past stored entries");

    a_empty_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_o_entry_valid) |->
            (r_o_run_last && r_o_cnt[0] == '0 && r_o_cnt[1] == '0 &&
             r_o_cnt[2] == '0 && r_o_cnt[3] == '0))
        else $error("empty-run result with nonzero counts");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> (r_store_cnt == '0 && !r_up_seen && !r_right_seen))
        else $error("run state not cleared after final result");

endmodule

FILE: src/rnc_classify.sv
// rnc_classify: touch test and side/corner classification of one rectangle.
// Depends on rnc_pkg; purely combinational.
module rnc_classify import rnc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0] i_oxl,
    input  logic [COORD_BITS-1:0] i_oxh,
    input  logic [COORD_BITS-1:0] i_oyl,
    input  logic [COORD_BITS-1:0] i_oyh,
    input  logic [COORD_BITS-1:0] i_rxl,
    input  logic [COORD_BITS-1:0] i_rxh,
    input  logic [COORD_BITS-1:0] i_ryl,
    input  logic [COORD_BITS-1:0] i_ryh,
    output t_class                o_cls
);

    // closed intervals share a point, bounds taken literally
    function automatic logic touch(input logic [COORD_BITS-1:0] alo, ahi, blo, bhi);
        return (blo >= alo && blo <= ahi) || (bhi >= alo && bhi <= ahi) ||
               (alo >= blo && alo <= bhi) || (ahi >= blo && ahi <= bhi);
    endfunction

    logic [COORD_BITS-1:0]         xm, ym, mx, my, nx, ny, sx, sy, len;
    logic                          match, touching;
    t_pos                          pos;
    logic [COORD_BITS+FIELD_W-1:0] sx_ext, sy_ext, len_ext;

    always_comb begin
        xm  = i_oxh - COORD_BITS'(1);
        ym  = i_oyh - COORD_BITS'(1);
        mx  = (i_oxl > i_rxl) ? i_oxl : i_rxl;
        my  = (i_oyl > i_ryl) ? i_oyl : i_ryl;
        nx  = (i_oxh < i_rxh) ? i_oxh : i_rxh;
        ny  = (i_oyh < i_ryh) ? i_oyh : i_ryh;
        sx  = '0;
        sy  = '0;
        len = COORD_BITS'(1);
        pos = POS_UP;
        match = 1'b1;
        if (i_rxl == i_oxl && i_rxh == i_oxh) begin
            sx  = i_oxl;
            len = i_oxh - i_oxl;
            if (i_oyl < i_ryl) begin
                sy = ym; pos = POS_UP;
            end else begin
                sy = i_oyl; pos = POS_DOWN;
            end
        end else if (i_ryl == i_oyl && i_ryh == i_oyh) begin
            sy  = i_oyl;
            len = i_oyh - i_oyl;
            if (i_oxl < i_rxl) begin
                sx = xm; pos = POS_RIGHT;
            end else begin
                sx = i_oxl; pos = POS_LEFT;
            end
        end else if (i_rxl == i_oxh) begin
            sx = xm;
            if (i_ryl == i_oyh) begin
                sy = ym; pos = POS_UPRIGHT;
            end else if (i_ryh == i_oyl) begin
                sy = i_oyl; pos = POS_DOWNRIGHT;
            end else begin
                sy = my; len = ny - my; pos = POS_RIGHT;
            end
        end else if (i_rxh == i_oxl) begin
            sx = i_oxl;
            if (i_ryl == i_oyh) begin
                sy = ym; pos = POS_UPLEFT;
            end else if (i_ryh == i_oyl) begin
                sy = i_oyl; pos = POS_DOWNLEFT;
            end else begin
                sy = my; len = ny - my; pos = POS_LEFT;
            end
        end else if (i_ryl == i_oyh) begin
            sy = ym; sx = mx; len = nx - mx; pos = POS_UP;
        end else if (i_ryh == i_oyl) begin
            sy = i_oyl; sx = mx; len = nx - mx; pos = POS_DOWN;
        end else begin
            match = 1'b0;
        end
        touching = touch(i_oxl, i_oxh, i_rxl, i_rxh) && touch(i_oyl, i_oyh, i_ryl, i_ryh);

        // cut to the 16-bit result fields
        sx_ext  = {{FIELD_W{1'b0}}, sx};
        sy_ext  = {{FIELD_W{1'b0}}, sy};
        len_ext = {{FIELD_W{1'b0}}, len};
        o_cls.hit = touching && match;
        o_cls.pos = pos;
        o_cls.sx  = sx_ext[FIELD_W-1:0];
        o_cls.sy  = sy_ext[FIELD_W-1:0];
        o_cls.len = len_ext[FIELD_W-1:0];
    end

endmodule
